/* rtl/piezo_hit_scan_mask_velocity_top_macros.svh */
// Assertion macros for the piezo hit detector.
// Each expects clk and rst_n to be visible where it is used.
`ifndef PIEZO_HIT_SCAN_MASK_VELOCITY_TOP_MACROS_SVH
`define PIEZO_HIT_SCAN_MASK_VELOCITY_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PHSMV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PHSMV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/phsmv_pkg.sv */
`default_nettype none

package phsmv_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int TIME_BITS      = 32;
    localparam int NORM_FRAC_BITS = 16;
    localparam int CFG_BITS       = 12;
    localparam int INDEX_BITS     = 3;
    localparam int VEL_BITS       = 7;

    // register indexes
    localparam logic [INDEX_BITS-1:0] REG_THRESHOLD   = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_PEAK_MAX    = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_SCAN_TIME   = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_MASK_TIME   = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_CURVE_SHAPE = 3'd4;

    localparam logic [11:0] RST_THRESHOLD   = 12'd200;
    localparam logic [11:0] RST_PEAK_MAX    = 12'd4095;
    localparam logic [7:0]  RST_SCAN_TIME   = 8'd3;
    localparam logic [9:0]  RST_MASK_TIME   = 10'd30;
    localparam logic [11:0] RST_CURVE_SHAPE = 12'd256;

    localparam logic [VEL_BITS-1:0] VEL_MIN   = 7'd1;
    localparam logic [VEL_BITS-1:0] VEL_MAX   = 7'd127;
    localparam logic [31:0]         VEL_SCALE = 32'd126;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SCAN = 2'd1,
        PH_MASK = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        V_IDLE,
        V_DIV1,
        V_LEAD,
        V_LOGM,
        V_LOGU,
        V_LCALC,
        V_DIV2,
        V_EXPI,
        V_EXPM,
        V_EXPU,
        V_FIN,
        V_SCALEM,
        V_SCALEU,
        V_DONE
    } vstate_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]   now_ms;
    } in_item_t;

    typedef struct packed {
        logic [VEL_BITS-1:0] velocity;
        logic [11:0]         peak_level;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [11:0] peak;
        logic [11:0] threshold;
        logic [11:0] peak_max;
        logic [11:0] curve_shape;
    } vel_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [VEL_BITS-1:0] velocity;
    } vel_sts_t;

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] xv;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        xv   = x;
        for (int i = 0; i < 32; i++)
        begin
            if (xv >= res + bitv)
            begin
                xv  = xv - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q0.30 factors 2^-(2^-i), i = 1..16, packed with i = 1 at the bottom
    function automatic logic [16*30-1:0] exp_table();
        logic [63:0]        s;
        logic [16*30-1:0]   tab;
        s   = 64'd1 << 29;
        tab = '0;
        for (int i = 0; i < 16; i++)
        begin
            s = isqrt64(s << 30);
            tab[i*30 +: 30] = s[29:0];
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

/* rtl/phsmv_mul.sv */
`default_nettype none

module phsmv_mul (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] p
);

    logic [63:0] p_reg;

    // register the product before anything uses it
    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* rtl/phsmv_vel.sv */
`default_nettype none

module phsmv_vel (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire phsmv_pkg::vel_req_t req,
    output phsmv_pkg::vel_sts_t      sts
);

    import phsmv_pkg::*;

    localparam logic [16*30-1:0] EXP_TAB = exp_table();

    vstate_t     state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [11:0] rem_reg, rem_next;
    logic [28:0] dvd_reg, dvd_next;
    logic [11:0] dvs_reg, dvs_next;
    logic [16:0] m_reg, m_next;
    logic [3:0]  p_reg, p_next;
    logic [15:0] frac_reg, frac_next;
    logic [30:0] r_reg, r_next;
    logic [12:0] k_reg, k_next;
    logic [15:0] fexp_reg, fexp_next;
    logic [6:0]  vel_reg, vel_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    logic [11:0] range_w, span_w;
    logic [12:0] rem_sh;
    logic        ge;
    logic [3:0]  lead;
    logic [4:0]  lsh;
    logic [17:0] sq;
    logic [4:0]  lhi;
    logic [20:0] lval;
    logic [3:0]  tidx;
    logic [4:0]  rsh;
    logic [7:0]  vsum;

    phsmv_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // shared helpers
    always_comb
    begin
        range_w = (req.peak > req.threshold) ? req.peak - req.threshold : 12'd0;
        span_w  = (req.peak_max > req.threshold) ? req.peak_max - req.threshold : 12'd0;
        if (span_w == 12'd0)
        begin
            span_w = 12'd1;
        end
        rem_sh = {rem_reg, dvd_reg[28]};
        ge     = rem_sh >= {1'b0, dvs_reg};
        lead   = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (dvd_reg[i])
            begin
                lead = 4'(i);
            end
        end
        lsh  = 5'd16 - {1'b0, lead};
        sq   = prod[33:16];
        lhi  = 5'd16 - {1'b0, p_reg};
        lval = {lhi, 16'd0} - {5'd0, frac_reg};
        tidx = 4'(5'd16 - cnt_reg);
        rsh  = k_reg[4:0] + 5'd14;
        vsum = {1'b0, prod[22:16]} + 8'd1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            V_IDLE:
            begin
                if (req.start)
                begin
                    if (range_w >= span_w || range_w == 12'd0)
                    begin
                        state_next = V_DONE;
                    end
                    else
                    begin
                        state_next = V_DIV1;
                    end
                end
            end
            V_DIV1:   state_next = (cnt_reg == 5'd1) ? V_LEAD : V_DIV1;
            V_LEAD:   state_next = V_LOGM;
            V_LOGM:   state_next = V_LOGU;
            V_LOGU:   state_next = (cnt_reg == 5'd1) ? V_LCALC : V_LOGM;
            V_LCALC:  state_next = V_DIV2;
            V_DIV2:   state_next = (cnt_reg == 5'd1) ? V_EXPI : V_DIV2;
            V_EXPI:   state_next = V_EXPM;
            V_EXPM:
            begin
                if (fexp_reg[15])
                begin
                    state_next = V_EXPU;
                end
                else
                begin
                    state_next = (cnt_reg == 5'd1) ? V_FIN : V_EXPM;
                end
            end
            V_EXPU:   state_next = (cnt_reg == 5'd1) ? V_FIN : V_EXPM;
            V_FIN:    state_next = V_SCALEM;
            V_SCALEM: state_next = V_SCALEU;
            V_SCALEU: state_next = V_DONE;
            V_DONE:   state_next = V_IDLE;
            default:  state_next = V_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        m_next    = m_reg;
        p_next    = p_reg;
        frac_next = frac_reg;
        r_next    = r_reg;
        k_next    = k_reg;
        fexp_next = fexp_reg;
        vel_next  = vel_reg;
        mul_a     = 32'd0;
        mul_b     = 32'd0;
        case (state_reg)
            V_IDLE:
            begin
                rem_next = range_w;
                dvd_next = '0;
                dvs_next = span_w;
                cnt_next = 5'd16;
                vel_next = (range_w >= span_w) ? VEL_MAX : VEL_MIN;
            end
            V_DIV1, V_DIV2:
            begin
                rem_next = ge ? 12'(rem_sh - {1'b0, dvs_reg}) : rem_sh[11:0];
                dvd_next = {dvd_reg[27:0], ge};
                cnt_next = cnt_reg - 5'd1;
            end
            V_LEAD:
            begin
                p_next    = lead;
                m_next    = 17'({1'b0, dvd_reg[15:0]} << lsh);
                frac_next = '0;
                cnt_next  = 5'd16;
            end
            V_LOGM:
            begin
                mul_a = 32'(m_reg);
                mul_b = 32'(m_reg);
            end
            V_LOGU:
            begin
                m_next    = sq[17] ? sq[17:1] : sq[16:0];
                frac_next = {frac_reg[14:0], sq[17]};
                cnt_next  = cnt_reg - 5'd1;
            end
            V_LCALC:
            begin
                rem_next = '0;
                dvd_next = {lval, 8'd0};
                dvs_next = (req.curve_shape == 12'd0) ? 12'd1 : req.curve_shape;
                cnt_next = 5'd29;
            end
            V_EXPI:
            begin
                k_next    = dvd_reg[28:16];
                fexp_next = dvd_reg[15:0];
                r_next    = 31'd1 << 30;
                cnt_next  = 5'd16;
            end
            V_EXPM:
            begin
                mul_a = 32'(r_reg);
                mul_b = 32'(EXP_TAB[tidx*30 +: 30]);
                if (!fexp_reg[15])
                begin
                    fexp_next = {fexp_reg[14:0], 1'b0};
                    cnt_next  = cnt_reg - 5'd1;
                end
            end
            V_EXPU:
            begin
                r_next    = prod[60:30];
                fexp_next = {fexp_reg[14:0], 1'b0};
                cnt_next  = cnt_reg - 5'd1;
            end
            V_FIN:
            begin
                r_next = (k_reg > 13'd16) ? 31'd0 : (r_reg >> rsh);
            end
            V_SCALEM:
            begin
                mul_a = 32'(r_reg);
                mul_b = VEL_SCALE;
            end
            V_SCALEU:
            begin
                vel_next = (vsum > 8'(VEL_MAX)) ? VEL_MAX : vsum[6:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= V_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        m_reg    <= m_next;
        p_reg    <= p_next;
        frac_reg <= frac_next;
        r_reg    <= r_next;
        k_reg    <= k_next;
        fexp_reg <= fexp_next;
        vel_reg  <= vel_next;
    end

    assign sts.busy     = (state_reg != V_IDLE);
    assign sts.done     = (state_reg == V_DONE);
    assign sts.velocity = vel_reg;

endmodule

`default_nettype wire

/* rtl/piezo_hit_scan_mask_velocity_top.sv */
// Piezo drum pad hit detector for one pad. Each sample transaction carries
// a 12-bit converter reading and a free-running millisecond timestamp. While
// idle, a sample above threshold opens a scan window of scan_time ms in which
// the highest sample is kept; the first sample at or past the end of that
// window closes it and produces one hit transaction (velocity 1..127 and the
// peak level), after which samples are ignored for mask_time ms. Time
// differences wrap modulo 2^32. Velocity is the peak above threshold over
// (peak_max - threshold), raised to 256/curve_shape through fixed-point
// log2 and exp2, scaled to 1..127. Samples that do not close a scan are
// taken one per cycle. The one that closes a scan stalls the sample side
// while the shaping sequencer runs two restoring dividers (16 and 29 steps,
// one bit a cycle), the 16-step log2 squaring loop and the 16-step exp2
// product loop, which share a single registered multiplier: a product is
// issued in a multiply state and used in an update state, which exp2 enters
// only on set exponent bits. The hit is offered in the same cycle as the
// stall ends. Peaks at or beyond peak_max, or not above threshold, skip the
// shaping steps, stall for one cycle and offer the hit as that stall ends.
// While a hit transaction waits to be taken, samples are held as soon as a
// new scan has opened. Registers must be written through wr_en/reg_index/
// wr_data only while the block is idle; the block does not enforce this.

`default_nettype none

module piezo_hit_scan_mask_velocity_top (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  smp_valid,
    output logic                       smp_stall,
    input  wire phsmv_pkg::in_item_t   smp_data,
    output logic                       hit_valid,
    input  wire logic                  hit_stall,
    output phsmv_pkg::out_item_t       hit_data,
    input  wire logic                  wr_en,
    input  wire logic [2:0]            reg_index,
    input  wire logic [11:0]           wr_data
);

    import phsmv_pkg::*;

    // configuration
    logic [11:0] threshold_reg;
    logic [11:0] peak_max_reg;
    logic [7:0]  scan_time_reg;
    logic [9:0]  mask_time_reg;
    logic [11:0] curve_shape_reg;

    // hit tracking
    phase_t      phase_reg, phase_next;
    logic [11:0] peak_seen_reg, peak_seen_next;
    logic [31:0] phase_start_reg, phase_start_next;

    // result holding register
    logic        out_valid_reg, out_valid_next;
    logic [11:0] out_peak_reg, out_peak_next;
    logic [6:0]  out_vel_reg, out_vel_next;
    logic [11:0] pend_peak_reg, pend_peak_next;

    logic        smp_take;
    logic        hit_take;
    logic [31:0] elapsed;
    logic [11:0] peak_upd;
    logic        scan_over;
    vel_req_t    vreq;
    vel_sts_t    vsts;

    assign smp_take = smp_valid && !smp_stall;
    assign hit_take = out_valid_reg && !hit_stall;
    assign elapsed  = smp_data.now_ms - phase_start_reg;
    assign peak_upd = (smp_data.sample > peak_seen_reg) ? smp_data.sample : peak_seen_reg;
    assign scan_over = (elapsed >= 32'(scan_time_reg));

    // Hold samples while the sequencer runs, and while a pending hit could
    // be joined by another one.
    assign smp_stall = vsts.busy || (out_valid_reg && phase_reg == PH_SCAN);

    // Start the sequencer on the sample that closes a scan.
    assign vreq.start = smp_take && (phase_reg == PH_SCAN) && scan_over;

    // Scan, mask and idle phases
    always_comb
    begin
        phase_next       = phase_reg;
        peak_seen_next   = peak_seen_reg;
        phase_start_next = phase_start_reg;
        pend_peak_next   = pend_peak_reg;
        if (smp_take)
        begin
            case (phase_reg)
                PH_SCAN:
                begin
                    peak_seen_next = peak_upd;
                    if (scan_over)
                    begin
                        pend_peak_next   = peak_upd;
                        phase_next       = PH_MASK;
                        phase_start_next = smp_data.now_ms;
                    end
                end
                PH_MASK:
                begin
                    if (elapsed >= 32'(mask_time_reg))
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    // idle, and the unused code behaves the same
                    if (smp_data.sample > threshold_reg)
                    begin
                        phase_next       = PH_SCAN;
                        peak_seen_next   = smp_data.sample;
                        phase_start_next = smp_data.now_ms;
                    end
                end
            endcase
        end
    end

    assign vreq.peak        = pend_peak_next;
    assign vreq.threshold   = threshold_reg;
    assign vreq.peak_max    = peak_max_reg;
    assign vreq.curve_shape = curve_shape_reg;

    phsmv_vel u_vel (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (vreq),
        .sts   (vsts)
    );

    // Load the result when the sequencer finishes; drop it once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_peak_next  = out_peak_reg;
        out_vel_next   = out_vel_reg;
        if (hit_take)
        begin
            out_valid_next = 1'b0;
        end
        if (vsts.done)
        begin
            out_valid_next = 1'b1;
            out_peak_next  = pend_peak_reg;
            out_vel_next   = vsts.velocity;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= RST_THRESHOLD;
            peak_max_reg    <= RST_PEAK_MAX;
            scan_time_reg   <= RST_SCAN_TIME;
            mask_time_reg   <= RST_MASK_TIME;
            curve_shape_reg <= RST_CURVE_SHAPE;
            phase_reg       <= PH_IDLE;
            peak_seen_reg   <= '0;
            phase_start_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (reg_index)
                    REG_THRESHOLD:   threshold_reg   <= wr_data;
                    REG_PEAK_MAX:    peak_max_reg    <= wr_data;
                    REG_SCAN_TIME:   scan_time_reg   <= wr_data[7:0];
                    REG_MASK_TIME:   mask_time_reg   <= wr_data[9:0];
                    REG_CURVE_SHAPE: curve_shape_reg <= wr_data;
                    default:
                    begin
                    end
                endcase
            end
            phase_reg       <= phase_next;
            peak_seen_reg   <= peak_seen_next;
            phase_start_reg <= phase_start_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_peak_reg  <= out_peak_next;
        out_vel_reg   <= out_vel_next;
        pend_peak_reg <= pend_peak_next;
    end

    assign hit_valid           = out_valid_reg;
    assign hit_data.velocity   = out_vel_reg;
    assign hit_data.peak_level = out_peak_reg;

endmodule

`default_nettype wire

/* rtl/phsmv_chk.sv */
`default_nettype none

`include "piezo_hit_scan_mask_velocity_top_macros.svh"

module phsmv_chk (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 smp_stall,
    input  wire logic                 hit_valid,
    input  wire logic                 hit_stall,
    input  wire phsmv_pkg::out_item_t hit_data
);

    import phsmv_pkg::*;

    `PHSMV_ASSERT_NEXT(a_hit_hold, hit_valid && hit_stall,
        hit_valid && $stable(hit_data), "hit dropped or changed while stalled")

    `PHSMV_ASSERT_SAME(a_vel_nonzero, hit_valid, hit_data.velocity != '0,
        "zero velocity on a hit")

    `PHSMV_ASSERT_SAME(a_hit_after_busy, $rose(hit_valid), $past(smp_stall),
        "hit appeared without the sequencer holding samples")

endmodule

bind piezo_hit_scan_mask_velocity_top phsmv_chk u_chk (.*);

`default_nettype wire

/* test/piezo_hit_scan_mask_velocity_top_test.sv */
`default_nettype none

// Scoreboard: keeps its own copy of the pad state and registers and the
// queue of hits still owed by the block.
class hit_scoreboard;
    logic [11:0] threshold;
    logic [11:0] peak_max;
    logic [7:0]  scan_time;
    logic [9:0]  mask_time;
    logic [11:0] curve_shape;
    phsmv_pkg::phase_t phase;
    logic [11:0] peak_seen;
    logic [31:0] phase_start;
    phsmv_pkg::out_item_t pending_hits[$];
    int errors;

    function new();
        threshold   = phsmv_pkg::RST_THRESHOLD;
        peak_max    = phsmv_pkg::RST_PEAK_MAX;
        scan_time   = phsmv_pkg::RST_SCAN_TIME;
        mask_time   = phsmv_pkg::RST_MASK_TIME;
        curve_shape = phsmv_pkg::RST_CURVE_SHAPE;
        phase       = phsmv_pkg::PH_IDLE;
        peak_seen   = '0;
        phase_start = '0;
        errors      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [11:0] val);
        case (idx)
            phsmv_pkg::REG_THRESHOLD:   threshold   = val;
            phsmv_pkg::REG_PEAK_MAX:    peak_max    = val;
            phsmv_pkg::REG_SCAN_TIME:   scan_time   = val[7:0];
            phsmv_pkg::REG_MASK_TIME:   mask_time   = val[9:0];
            phsmv_pkg::REG_CURVE_SHAPE: curve_shape = val;
            default: ;
        endcase
    endfunction

    static function logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function logic [6:0] shaped_velocity(logic [11:0] peak);
        logic [63:0] one;
        logic [63:0] range_v;
        logic [63:0] span;
        logic [63:0] norm;
        logic [63:0] shaped;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] log_v;
        logic [63:0] e;
        logic [63:0] k;
        logic [63:0] fexp;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] cs;
        logic [63:0] vel;
        int p;
        one = 64'd1 << 16;
        range_v = (peak > threshold) ? 64'(peak - threshold) : 64'd0;
        span = (peak_max > threshold) ? 64'(peak_max - threshold) : 64'd0;
        if (span < 1) span = 1;
        norm = (range_v >= span) ? one : (range_v << 16) / span;
        if (norm == 0)
            shaped = 0;
        else if (norm >= one)
            shaped = one;
        else
        begin
            p = 0;
            frac = 0;
            cs = (curve_shape != 0) ? 64'(curve_shape) : 64'd1;
            while ((norm >> (p + 1)) != 0) p++;
            m = norm << (16 - p);
            for (int i = 1; i <= 16; i++)
            begin
                m = (m * m) >> 16;
                if (m >= (one << 1))
                begin
                    m = m >> 1;
                    frac = frac | (64'd1 << (16 - i));
                end
            end
            log_v = (64'(16 - p) << 16) - frac;
            e = (log_v * 256) / cs;
            k = e >> 16;
            fexp = e & (one - 1);
            r = 64'd1 << 30;
            s = 64'd1 << 29;
            for (int i = 1; i <= 16; i++)
            begin
                s = int_sqrt(s << 30);
                if (fexp[16 - i]) r = (r * s) >> 30;
            end
            k = k + 14;
            shaped = (k >= 64) ? 64'd0 : (r >> k);
        end
        vel = ((shaped * 126) >> 16) + 1;
        if (vel > 127) vel = 127;
        return vel[6:0];
    endfunction

    // Advance the pad state by one accepted sample; queue a hit if one is due.
    function void note_sample(phsmv_pkg::in_item_t it);
        logic [31:0] elapsed;
        phsmv_pkg::out_item_t hit;
        elapsed = it.now_ms - phase_start;
        if (phase == phsmv_pkg::PH_SCAN)
        begin
            if (it.sample > peak_seen) peak_seen = it.sample;
            if (elapsed >= scan_time)
            begin
                hit.velocity = shaped_velocity(peak_seen);
                hit.peak_level = peak_seen;
                pending_hits.push_back(hit);
                phase = phsmv_pkg::PH_MASK;
                phase_start = it.now_ms;
            end
        end
        else if (phase == phsmv_pkg::PH_MASK)
        begin
            if (elapsed >= mask_time) phase = phsmv_pkg::PH_IDLE;
        end
        else if (it.sample > threshold)
        begin
            phase = phsmv_pkg::PH_SCAN;
            peak_seen = it.sample;
            phase_start = it.now_ms;
        end
    endfunction

    function void check_hit(phsmv_pkg::out_item_t got);
        phsmv_pkg::out_item_t want;
        if (pending_hits.size() == 0)
        begin
            $display("%0t: unexpected hit, expected none, actual vel %0d peak %0d",
                     $time, got.velocity, got.peak_level);
            errors++;
            return;
        end
        want = pending_hits.pop_front();
        if (got.velocity !== want.velocity)
        begin
            $display("%0t: velocity mismatch, expected %0d, actual %0d",
                     $time, want.velocity, got.velocity);
            errors++;
        end
        if (got.peak_level !== want.peak_level)
        begin
            $display("%0t: peak_level mismatch, expected %0d, actual %0d",
                     $time, want.peak_level, got.peak_level);
            errors++;
        end
    endfunction
endclass

module piezo_hit_scan_mask_velocity_top_test;
    import phsmv_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      smp_valid;
    logic      smp_stall;
    in_item_t  smp_data;
    logic      hit_valid;
    logic      hit_stall;
    out_item_t hit_data;
    logic        wr_en;
    logic [2:0]  reg_index;
    logic [11:0] wr_data;

    hit_scoreboard sb;
    logic [31:0] clock_ms;     // running timestamp for generated samples
    bit          hold_off;     // receiver hold-off requested by stimulus
    bit          no_idle;      // stretch with no idling on either side

    piezo_hit_scan_mask_velocity_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data),
        .hit_valid (hit_valid),
        .hit_stall (hit_stall),
        .hit_data  (hit_data),
        .wr_en     (wr_en),
        .reg_index (reg_index),
        .wr_data   (wr_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Offer one sample transaction and hold it until accepted; a random idle
    // gap may come first. The scoreboard is told at the accepting edge.
    // Valid stays high afterwards so back-to-back transactions need no gap;
    // drain() drops it.
    task automatic send_sample(logic [11:0] smp, logic [31:0] now);
        in_item_t it;
        it.sample = smp;
        it.now_ms = now;
        while (!no_idle && $urandom_range(99) < 24)
        begin
            smp_valid <= 1'b0;
            @(posedge clk);
        end
        smp_valid <= 1'b1;
        smp_data  <= it;
        do
            @(posedge clk);
        while (smp_stall);
        sb.note_sample(it);
    endtask

    // Drop valid, wait until every owed hit has arrived, then let the
    // sequencer drain.
    task automatic drain();
        smp_valid <= 1'b0;
        while (sb.pending_hits.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        wr_en     <= 1'b1;
        reg_index <= idx;
        wr_data   <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // One well-formed hit: a trigger, a scan, then mask-window samples.
    task automatic strike(int n_scan, int n_mask);
        send_sample(12'($urandom_range(4095)), clock_ms);
        for (int i = 0; i < n_scan; i++)
        begin
            clock_ms = clock_ms + $urandom_range(2);
            send_sample(12'($urandom), clock_ms);
        end
        for (int i = 0; i < n_mask; i++)
        begin
            clock_ms = clock_ms + $urandom_range(40);
            send_sample(12'($urandom), clock_ms);
        end
    endtask

    task automatic random_settings(bit extreme);
        drain();
        if (extreme)
        begin
            write_reg(REG_THRESHOLD,   ($urandom_range(1)) ? 12'd0 : 12'd4095);
            write_reg(REG_PEAK_MAX,    ($urandom_range(1)) ? 12'd0 : 12'd4095);
            write_reg(REG_SCAN_TIME,   ($urandom_range(1)) ? 12'd0 : 12'd255);
            write_reg(REG_MASK_TIME,   ($urandom_range(1)) ? 12'd0 : 12'd1023);
            write_reg(REG_CURVE_SHAPE, ($urandom_range(1)) ? 12'd16 : 12'd4095);
        end
        else
        begin
            write_reg(REG_THRESHOLD,   12'($urandom_range(1500)));
            write_reg(REG_PEAK_MAX,    12'($urandom_range(4095)));
            write_reg(REG_SCAN_TIME,   12'($urandom_range(6)));
            write_reg(REG_MASK_TIME,   12'($urandom_range(60)));
            write_reg(REG_CURVE_SHAPE, 12'($urandom_range(4095, 16)));
        end
    endtask

    // Receiver: random stall, a clear stretch when asked, a long counted
    // hold-off when the stimulus requests one. Check at each accepting edge.
    initial
    begin
        int hold_cnt;
        hit_stall <= 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && hit_valid && !hit_stall)
                sb.check_hit(hit_data);
            if (hold_off && hold_cnt == 0)
                hold_cnt = 3000;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                if (hold_cnt == 0) hold_off = 0;
                hit_stall <= 1'b1;
            end
            else
                hit_stall <= !no_idle && ($urandom_range(99) < 24);
        end
    end

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        smp_valid = 1'b0;
        smp_data  = '0;
        wr_en     = 1'b0;
        reg_index = '0;
        wr_data   = '0;
        hold_off  = 0;
        no_idle   = 0;
        clock_ms  = 32'hFFFF_FF00;   // wrap comes early in the run
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, field extremes, zero scan, wrap.
        send_sample(12'd4095, 32'hFFFF_FFFE);
        send_sample(12'd0,    32'hFFFF_FFFF);
        send_sample(12'd100,  32'h0000_0001);   // closes across the wrap
        send_sample(12'd4095, 32'h0000_0100);   // mask over
        send_sample(12'd201,  32'h0000_0200);
        send_sample(12'd0,    32'h0000_0203);   // weakest hit
        drain();
        write_reg(REG_SCAN_TIME, 12'd0);
        write_reg(REG_MASK_TIME, 12'd0);
        write_reg(REG_CURVE_SHAPE, 12'd16);
        write_reg(REG_THRESHOLD, 12'd0);
        write_reg(REG_PEAK_MAX, 12'd0);         // span clamps to one
        write_reg(3'd7, 12'hFFF);               // unknown index: ignored
        send_sample(12'd1, 32'hAAAA_AAAA);
        send_sample(12'd0, 32'h5555_5555);
        send_sample(12'd0, 32'h5555_5556);
        drain();
        write_reg(REG_PEAK_MAX, 12'd4095);
        write_reg(REG_CURVE_SHAPE, 12'd4095);
        write_reg(REG_THRESHOLD, 12'd4095);     // nothing can trigger
        send_sample(12'd4095, 32'd10);
        drain();
        write_reg(REG_THRESHOLD, 12'd50);
        write_reg(REG_CURVE_SHAPE, 12'd700);
        send_sample(12'd1000, 32'd20);
        send_sample(12'd2345, 32'd20);
        send_sample(12'd3, 32'd21);

        // Fill the block while the receiver holds off for a long stretch.
        hold_off = 1;
        for (int i = 0; i < 30; i++)
            strike(1, 1);
        // Pause the sender until every owed hit is in.
        drain();

        // Random phases: mostly well-formed strikes, some noise.
        for (int ph = 0; ph < 12; ph++)
        begin
            random_settings(ph % 4 == 3);
            no_idle = (ph == 5);
            for (int j = 0; j < 35; j++)
            begin
                if ($urandom_range(9) < 8)
                    strike($urandom_range(5), $urandom_range(3));
                else
                begin
                    clock_ms = clock_ms + $urandom;
                    send_sample(12'($urandom), clock_ms);
                end
            end
        end
        no_idle = 0;

        drain();
        if (sb.errors == 0 && sb.pending_hits.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #10000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire
